// ===== rtl/core/rse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// shared types and codes of the risc subset executor
// ----------------------------------------------------------------------------
package rse_pkg;

  // item kinds carried in the opcode field of an input beat
  localparam logic [1:0] ITEM_EXEC     = 2'd0;
  localparam logic [1:0] ITEM_LOAD_REG = 2'd1;
  localparam logic [1:0] ITEM_LOAD_MEM = 2'd2;

  // primary opcodes, instruction bits 31:26
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // r-type function codes, instruction bits 5:0
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_SLT = 6'd42;

  // register file write port
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

endpackage

// ===== rtl/core/rse_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_item_if
// input channel: one instruction or preload beat
// ----------------------------------------------------------------------------
interface rse_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [31:0]        instruction;
  logic [4:0]         load_index;
  logic [9:0]         load_address;
  logic signed [31:0] load_value;

  modport source (
    output valid, opcode, instruction, load_index, load_address, load_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, instruction, load_index, load_address, load_value,
    output ready
  );
endinterface

// ===== rtl/core/rse_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_result_if
// output channel: one result beat per item
// ----------------------------------------------------------------------------
interface rse_result_if;
  logic               valid;
  logic               ready;
  logic               reg_written;
  logic [4:0]         reg_number;
  logic signed [31:0] reg_value;
  logic               mem_touched;
  logic [9:0]         mem_address;
  logic signed [31:0] mem_value;
  logic               address_error;
  logic               branch_taken;
  logic [15:0]        skip_count;
  logic               unknown_instruction;

  modport source (
    output valid, reg_written, reg_number, reg_value, mem_touched, mem_address,
           mem_value, address_error, branch_taken, skip_count,
           unknown_instruction,
    input  ready
  );
  modport sink (
    input  valid, reg_written, reg_number, reg_value, mem_touched, mem_address,
           mem_value, address_error, branch_taken, skip_count,
           unknown_instruction,
    output ready
  );
endinterface

// ===== rtl/core/risc_subset_instruction_executor.sv =====
// each input beat passes the read, execute and retire stages to its result beat
// throughput: one item per cycle unless stalled; a lw result feeds the very next item
// reg operands come from the register file read, bypassed from the retire stage
// reset clears the pipeline and the register file valid bits at once
// after reset the data memory is zeroed one word a cycle, all MEM_WORDS words,
// and no input beat is taken until that pass ends
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// risc_subset_instruction_executor
// executes add, sub, slt, addi, lw, sw, beq, bne and preload items
// ----------------------------------------------------------------------------
module risc_subset_instruction_executor #(
  parameter int MEM_WORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  rse_item_if.sink     item,
  rse_result_if.source result
);

  localparam int AW = $clog2(MEM_WORDS);

  // handshake and stage occupancy
  logic acc;
  logic out_v;
  logic out_free;
  logic s1_v;
  logic s1_move;
  logic s2_v;
  logic s2_free;
  logic s2_move;
  logic clearing;

  // stage 1: captured item, operands arrive from the register file
  logic [1:0]  s1_kind;
  logic [31:0] s1_ins;
  logic [4:0]  s1_lidx;
  logic [9:0]  s1_laddr;
  logic [31:0] s1_lval;

  logic [31:0] rf_rs_data;
  logic [31:0] rf_rt_data;
  rse_pkg::rf_wr_t rf_wr;

  // stage 2: executed item waiting for load data and retire
  logic        s2_we;
  logic [4:0]  s2_rnum;
  logic [31:0] s2_data;
  logic        s2_load;
  logic        s2_report;
  logic        s2_mt;
  logic [9:0]  s2_maddr;
  logic [31:0] s2_mval;
  logic        s2_aerr;
  logic        s2_br;
  logic [15:0] s2_skip;
  logic        s2_unk;
  logic [31:0] s2_wdata;

  logic [31:0] dm_rdata;

  // output register
  logic        o_rw;
  logic [4:0]  o_rnum;
  logic [31:0] o_rval;
  logic        o_mt;
  logic [9:0]  o_maddr;
  logic [31:0] o_mval;
  logic        o_aerr;
  logic        o_br;
  logic [15:0] o_skip;
  logic        o_unk;

  // decoded fields and execute results
  logic [5:0]    op;
  logic [5:0]    funct;
  logic [4:0]    rs;
  logic [4:0]    rt;
  logic [4:0]    rd;
  logic [15:0]   imm;
  logic [31:0]   simm;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [32:0]   ea;
  logic          ea_err;
  logic          laddr_ok;

  logic          n_we;
  logic [4:0]    n_rnum;
  logic [31:0]   n_data;
  logic          n_load;
  logic          n_report;
  logic          n_mt;
  logic [9:0]    n_maddr;
  logic [31:0]   n_mval;
  logic          n_aerr;
  logic          n_br;
  logic [15:0]   n_skip;
  logic          n_unk;
  logic          dm_we_c;
  logic          dm_re_c;
  logic [AW-1:0] dm_addr;
  logic [31:0]   dm_wdata;

  // pipeline flow: a stage moves on when the one after it has room
  assign out_free   = !out_v || result.ready;
  assign s2_free    = !s2_v || out_free;
  assign s2_move    = s2_v && out_free;
  assign s1_move    = s1_v && s2_free;
  assign item.ready = (!s1_v || s2_free) && !clearing;
  assign acc        = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (acc) begin
        s1_v <= 1'b1;
      end else if (s1_move) begin
        s1_v <= 1'b0;
      end
      if (s1_move) begin
        s2_v <= 1'b1;
      end else if (s2_move) begin
        s2_v <= 1'b0;
      end
      if (s2_move) begin
        out_v <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind  <= item.opcode;
      s1_ins   <= item.instruction;
      s1_lidx  <= item.load_index;
      s1_laddr <= item.load_address;
      s1_lval  <= item.load_value;
    end
  end

  // register file: read on accept, write on retire
  rse_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (acc),
    .rs_addr (item.instruction[25:21]),
    .rt_addr (item.instruction[20:16]),
    .rs_data (rf_rs_data),
    .rt_data (rf_rt_data),
    .wr      (rf_wr)
  );

  assign rf_wr.we   = s2_move && s2_we;
  assign rf_wr.addr = s2_rnum;
  assign rf_wr.data = s2_wdata;

  // ---------------------------------------------------------------------------
  // execute stage
  // ---------------------------------------------------------------------------
  assign op    = s1_ins[31:26];
  assign rs    = s1_ins[25:21];
  assign rt    = s1_ins[20:16];
  assign rd    = s1_ins[15:11];
  assign funct = s1_ins[5:0];
  assign imm   = s1_ins[15:0];
  assign simm  = {{16{imm[15]}}, imm};

  // the item in stage 2 is older and retires on the same edge this one leaves
  assign a = (s2_v && s2_we && s2_rnum == rs) ? s2_wdata : rf_rs_data;
  assign b = (s2_v && s2_we && s2_rnum == rt) ? s2_wdata : rf_rt_data;

  // effective word address, signed 33 bits so a negative sum is seen
  assign ea       = {a[31], a} + {simm[31], simm};
  assign ea_err   = ea[32] || (ea[31:0] >= 32'(MEM_WORDS));
  assign laddr_ok = {22'd0, s1_laddr} < 32'(MEM_WORDS);

  always_comb begin
    n_we     = 1'b0;
    n_rnum   = '0;
    n_data   = '0;
    n_load   = 1'b0;
    n_report = 1'b0;
    n_mt     = 1'b0;
    n_maddr  = '0;
    n_mval   = '0;
    n_aerr   = 1'b0;
    n_br     = 1'b0;
    n_skip   = '0;
    n_unk    = 1'b0;
    dm_we_c  = 1'b0;
    dm_re_c  = 1'b0;
    dm_addr  = AW'(ea[31:0]);
    dm_wdata = b;
    case (s1_kind)
      rse_pkg::ITEM_EXEC: begin
        case (op)
          rse_pkg::OP_RTYPE: begin
            n_rnum   = rd;
            n_report = 1'b1;
            case (funct)
              rse_pkg::FN_ADD: begin
                n_we   = rd != 5'd0;
                n_data = a + b;
              end
              rse_pkg::FN_SUB: begin
                n_we   = rd != 5'd0;
                n_data = a - b;
              end
              rse_pkg::FN_SLT: begin
                n_we   = rd != 5'd0;
                n_data = {31'd0, $signed(a) < $signed(b)};
              end
              default: begin
                n_unk = 1'b1;
              end
            endcase
          end
          rse_pkg::OP_ADDI: begin
            n_we     = rt != 5'd0;
            n_rnum   = rt;
            n_data   = a + simm;
            n_report = 1'b1;
          end
          rse_pkg::OP_LW: begin
            if (ea_err) begin
              n_aerr = 1'b1;
            end else begin
              n_mt     = 1'b1;
              n_maddr  = ea[9:0];
              n_load   = 1'b1;
              dm_re_c  = 1'b1;
              n_we     = rt != 5'd0;
              n_rnum   = rt;
              n_report = 1'b1;
            end
          end
          rse_pkg::OP_SW: begin
            if (ea_err) begin
              n_aerr = 1'b1;
            end else begin
              n_mt    = 1'b1;
              n_maddr = ea[9:0];
              n_mval  = b;
              dm_we_c = 1'b1;
            end
          end
          rse_pkg::OP_BEQ: begin
            if (a == b) begin
              n_br   = 1'b1;
              n_skip = imm;
            end
          end
          rse_pkg::OP_BNE: begin
            if (a != b) begin
              n_br   = 1'b1;
              n_skip = imm;
            end
          end
          default: begin
            n_unk = 1'b1;
          end
        endcase
      end
      rse_pkg::ITEM_LOAD_REG: begin
        // silent write, nothing reported
        n_we   = s1_lidx != 5'd0;
        n_rnum = s1_lidx;
        n_data = s1_lval;
      end
      rse_pkg::ITEM_LOAD_MEM: begin
        dm_we_c  = laddr_ok;
        dm_addr  = AW'({22'd0, s1_laddr});
        dm_wdata = s1_lval;
      end
      default: begin
        n_unk = 1'b1;
      end
    endcase
  end

  // data memory: loads and stores both access it as they leave execute,
  // so accesses stay in item order and need no bypass
  rse_dmem #(
    .WORDS (MEM_WORDS)
  ) u_dmem (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .we       (s1_move && dm_we_c),
    .re       (s1_move && dm_re_c),
    .addr     (dm_addr),
    .wdata    (dm_wdata),
    .rdata    (dm_rdata)
  );

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_we     <= n_we;
      s2_rnum   <= n_rnum;
      s2_data   <= n_data;
      s2_load   <= n_load;
      s2_report <= n_report;
      s2_mt     <= n_mt;
      s2_maddr  <= n_maddr;
      s2_mval   <= n_mval;
      s2_aerr   <= n_aerr;
      s2_br     <= n_br;
      s2_skip   <= n_skip;
      s2_unk    <= n_unk;
    end
  end

  // ---------------------------------------------------------------------------
  // retire stage: load data joins, register write, result beat formed
  // ---------------------------------------------------------------------------
  assign s2_wdata = s2_load ? dm_rdata : s2_data;

  always_ff @(posedge clk) begin
    if (s2_move) begin
      o_rw    <= s2_we && s2_report;
      o_rnum  <= (s2_we && s2_report) ? s2_rnum : 5'd0;
      o_rval  <= (s2_we && s2_report) ? s2_wdata : 32'd0;
      o_mt    <= s2_mt;
      o_maddr <= s2_maddr;
      o_mval  <= s2_load ? dm_rdata : s2_mval;
      o_aerr  <= s2_aerr;
      o_br    <= s2_br;
      o_skip  <= s2_skip;
      o_unk   <= s2_unk;
    end
  end

  assign result.valid               = out_v;
  assign result.reg_written         = o_rw;
  assign result.reg_number          = o_rnum;
  assign result.reg_value           = o_rval;
  assign result.mem_touched         = o_mt;
  assign result.mem_address         = o_maddr;
  assign result.mem_value           = o_mval;
  assign result.address_error       = o_aerr;
  assign result.branch_taken        = o_br;
  assign result.skip_count          = o_skip;
  assign result.unknown_instruction = o_unk;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // register zero is never reported as written
  a_no_reg0_write: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.reg_written && result.reg_number == 5'd0))
    else $error("write to register zero reported");

  // a faulting access neither touches memory nor writes a register
  a_fault_suppressed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.address_error |-> !result.mem_touched && !result.reg_written)
    else $error("address error with side effects");

  // no skip without a taken branch
  a_skip_only_taken: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.branch_taken |-> result.skip_count == 16'd0)
    else $error("skip count without taken branch");

  // a stalled retire stage keeps its item
  a_retire_holds: assert property (@(posedge clk) disable iff (rst)
    s2_v && !out_free |=> s2_v)
    else $error("retire stage lost an item");

  // nothing enters the pipeline while memory is being zeroed
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_v && !s2_v)
    else $error("item in flight during memory clear");

endmodule

// ===== rtl/core/rse_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_regfile
// 32 x 32 register file, two registered read ports, one write port
// ----------------------------------------------------------------------------
module rse_regfile (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [4:0]      rs_addr,
  input  logic [4:0]      rt_addr,
  output logic [31:0]     rs_data,
  output logic [31:0]     rt_data,
  input  rse_pkg::rf_wr_t wr
);

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic        rs_vq;
  logic        rt_vq;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.we) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read with bypass of a write on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      rs_vq <= 1'b0;
      rt_vq <= 1'b0;
    end else if (rd_en) begin
      rs_vq <= valid[rs_addr] || (wr.we && wr.addr == rs_addr);
      rt_vq <= valid[rt_addr] || (wr.we && wr.addr == rt_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_q <= (wr.we && wr.addr == rs_addr) ? wr.data : mem[rs_addr];
      rt_q <= (wr.we && wr.addr == rt_addr) ? wr.data : mem[rt_addr];
    end
  end

  assign rs_data = rs_vq ? rs_q : '0;
  assign rt_data = rt_vq ? rt_q : '0;

endmodule

// ===== rtl/core/rse_dmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_dmem
// data word memory, one port, registered read, zero fill after reset
// ----------------------------------------------------------------------------
module rse_dmem #(
  parameter  int WORDS = 1024,
  localparam int AW    = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          clearing,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0]   mem [WORDS];
  logic [AW-1:0] clr_cnt;

  // one word per cycle until the last entry is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(WORDS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
